### sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared definitions for the Scharr structure tensor front end
// Sizes, gradient weights, the weighted column sum and the stage payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  // Frame limits and the derived counter widths.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_WIDTH  = 18;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int CFG_W      = 11;

  // Pixel and result field widths.
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 16;
  localparam int GRD_W  = SUM_W + 1;
  localparam int PRD_W  = 2 * GRD_W;
  localparam int SQ_W   = 10;
  localparam int XY_W   = 11;
  localparam int POS_W  = 10;
  localparam int FLOOR_SHIFT = 20;
  localparam int RES_W  = 2 * SQ_W + XY_W + 2 * POS_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Scharr weights, already scaled by eight.
  localparam int W_EDGE = 3 * 8;
  localparam int W_MID  = 10 * 8;

  // Line store entry: pixel two rows up in the upper byte, one row up below.
  localparam int LINE_W = 2 * PIX_W;

  // Gradient stage payload.
  typedef struct packed {
    logic signed [GRD_W-1:0] dx;
    logic signed [GRD_W-1:0] dy;
    logic [POS_W-1:0]        crow;
    logic [POS_W-1:0]        ccol;
  } grad_t;

  // Result payload, packed so that grad_xx lands in the lowest bits.
  typedef struct packed {
    logic [POS_W-1:0]       ccol;
    logic [POS_W-1:0]       crow;
    logic signed [XY_W-1:0] xy;
    logic [SQ_W-1:0]        yy;
    logic [SQ_W-1:0]        xx;
  } res_t;

  // Weighted sum of three pixels along one column or row: 24*a + 80*b + 24*c.
  function automatic logic [SUM_W-1:0] wsum(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [SUM_W-1:0] ea;
    logic [SUM_W-1:0] eb;
    logic [SUM_W-1:0] ec;
    ea = SUM_W'(a);
    eb = SUM_W'(b);
    ec = SUM_W'(c);
    return SUM_W'(W_EDGE) * (ea + ec) + SUM_W'(W_MID) * eb;
  endfunction

endpackage

`default_nettype wire

### sv/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/sst_grad.sv
// ----------------------------------------------------------------------------
// sst_grad: raster position, line store, 3x3 window and Scharr gradients
// Tracks row and column, reads the two stored rows for the current column,
// shifts the window and registers dx and dy for interior centers.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_grad (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [sst_pkg::CFG_W-1:0]   width_cfg,
  input  wire logic                        pix_valid,
  output logic                             pix_ready,
  input  wire logic [sst_pkg::PIX_W-1:0]   pix,
  input  wire logic                        frame_start,
  output logic                             grad_valid,
  input  wire logic                        grad_ready,
  output sst_pkg::grad_t                   grad
);

  import sst_pkg::*;

  // Position counters.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Stage 1: item waiting for its line store data.
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_emit_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [POS_W-1:0]  s1_crow_r;
  logic              byp_r;
  logic [LINE_W-1:0] byp_data_r;

  // Window: two previous columns, top/middle/bottom each.
  logic [PIX_W-1:0] win_r [6];

  // Stage 2: gradient register.
  logic  s2_valid_r, s2_valid_nxt;
  grad_t s2_r;

  logic [CFG_W-1:0]  eff_w;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic              live;
  logic              acc;
  logic              take;
  logic              s2_free;
  logic              s1_adv;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line;
  logic [PIX_W-1:0]  ct, cm, cb;
  logic [LINE_W-1:0] wr_data;
  logic [SUM_W-1:0]  sum_l, sum_r, sum_t, sum_b;

  // Width in use, clamped to the supported range.
  always_comb begin
    eff_w = width_cfg;
    if (width_cfg < CFG_W'(MIN_WIDTH)) begin
      eff_w = CFG_W'(MIN_WIDTH);
    end else if (width_cfg > CFG_W'(MAX_WIDTH)) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end
  end

  // Position of the incoming pixel; a frame start restarts at the origin.
  assign cur_col = frame_start ? '0 : col_r;
  assign cur_row = frame_start ? '0 : row_r;
  assign live    = cur_row < ROW_W'(MAX_HEIGHT);

  // Handshake: stage 1 frees up when empty or when its item moves on.
  assign s2_free   = !s2_valid_r || grad_ready;
  assign s1_adv    = s1_valid_r && (!s1_emit_r || s2_free);
  assign pix_ready = !s1_valid_r || s1_adv;
  assign acc       = pix_valid && pix_ready;
  assign take      = acc && live;

  // Next position.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc && live) begin
      if ((CFG_W'(cur_col) + CFG_W'(1)) >= eff_w) begin
        col_nxt = '0;
        row_nxt = cur_row + ROW_W'(1);
      end else begin
        col_nxt = cur_col + COL_W'(1);
        row_nxt = cur_row;
      end
    end
  end

  // Line store: read at acceptance, write back as the item leaves stage 1.
  assign wr_data = {line[PIX_W-1:0], s1_pix_r};

  sst_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (wr_data),
    .re    (take),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  // A write to the same column in the same cycle as the read is forwarded.
  assign line = byp_r ? byp_data_r : ram_rdata;
  assign ct   = line[LINE_W-1:PIX_W];
  assign cm   = line[PIX_W-1:0];
  assign cb   = s1_pix_r;

  // Scharr sums over the window and the new column.
  assign sum_l = wsum(win_r[0], win_r[1], win_r[2]);
  assign sum_r = wsum(ct, cm, cb);
  assign sum_t = wsum(win_r[0], win_r[3], ct);
  assign sum_b = wsum(win_r[2], win_r[5], cb);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pix_ready) begin
      s1_valid_nxt = take;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r && s1_emit_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (s1_adv) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= ct;
        win_r[4] <= cm;
        win_r[5] <= cb;
      end
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r   <= pix;
      s1_col_r   <= cur_col;
      s1_crow_r  <= POS_W'(cur_row - ROW_W'(1));
      s1_emit_r  <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
      byp_r      <= s1_adv && (s1_col_r == cur_col);
      byp_data_r <= wr_data;
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r && s1_emit_r) begin
      s2_r.dx   <= $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
      s2_r.dy   <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
      s2_r.crow <= s1_crow_r;
      s2_r.ccol <= POS_W'(s1_col_r - COL_W'(1));
    end
  end

  assign grad_valid = s2_valid_r;
  assign grad       = s2_r;

endmodule

`default_nettype wire

### sv/sst_tensor.sv
// ----------------------------------------------------------------------------
// sst_tensor: structure tensor products and output register
// Squares and cross-multiplies the gradients, floors by 2^20 and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_tensor (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           grad_valid,
  output logic                grad_ready,
  input  wire sst_pkg::grad_t grad,
  output logic                res_valid,
  input  wire logic           res_ready,
  output sst_pkg::res_t       res
);

  import sst_pkg::*;

  logic              res_valid_r, res_valid_nxt;
  res_t              res_r;
  logic signed [PRD_W-1:0] p_xx, p_yy, p_xy;
  logic signed [PRD_W-1:0] f_xx, f_yy, f_xy;

  assign grad_ready = !res_valid_r || res_ready;

  // Products and arithmetic floor by 2^20.
  assign p_xx = grad.dx * grad.dx;
  assign p_yy = grad.dy * grad.dy;
  assign p_xy = grad.dy * grad.dx;
  assign f_xx = p_xx >>> FLOOR_SHIFT;
  assign f_yy = p_yy >>> FLOOR_SHIFT;
  assign f_xy = p_xy >>> FLOOR_SHIFT;

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (grad_ready) begin
      res_valid_nxt = grad_valid;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (grad_ready && grad_valid) begin
      res_r.xx   <= f_xx[SQ_W-1:0];
      res_r.yy   <= f_yy[SQ_W-1:0];
      res_r.xy   <= f_xy[XY_W-1:0];
      res_r.crow <= grad.crow;
      res_r.ccol <= grad.ccol;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

### sv/scharr_structure_tensor.sv
// ----------------------------------------------------------------------------
// scharr_structure_tensor: Scharr gradient structure tensor front end
// Pipeline: a result passes the input register with line store read, the
//   gradient register and the product register after the edge that accepts
//   its completing pixel.
// Throughput: one pixel per cycle while the result stream does not stall, set by
//   the single line store RAM with one read and one write port per cycle.
// Reset: synchronous, active low; clears position, window, valids and sets
//   the width register to 1024. The line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module scharr_structure_tensor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration: image_width.
  input  wire logic                            cfg_wr_en,
  input  wire logic [sst_pkg::CFG_W-1:0]       cfg_wr_data,
  // Input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sst_pkg::PIX_W-1:0]       in_tdata,   // [7:0] pixel
  input  wire logic                            in_tuser,   // [0] frame_start
  // Result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [9:0] grad_xx, [19:10] grad_yy, [30:20] grad_xy, [40:31] center_row,
  // [50:41] center_col, upper bits zero
  output logic [sst_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  import sst_pkg::*;

  logic [CFG_W-1:0] width_r;
  logic             grad_valid;
  logic             grad_ready;
  grad_t            grad;
  res_t             res;

  // Width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_W'(MAX_WIDTH);
    end else if (cfg_wr_en) begin
      width_r <= cfg_wr_data;
    end
  end

  sst_grad u_grad (
    .clk         (clk),
    .rst_n       (rst_n),
    .width_cfg   (width_r),
    .pix_valid   (in_tvalid),
    .pix_ready   (in_tready),
    .pix         (in_tdata),
    .frame_start (in_tuser),
    .grad_valid  (grad_valid),
    .grad_ready  (grad_ready),
    .grad        (grad)
  );

  sst_tensor u_tensor (
    .clk        (clk),
    .rst_n      (rst_n),
    .grad_valid (grad_valid),
    .grad_ready (grad_ready),
    .grad       (grad),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

  // Nothing is in flight right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !grad_valid)
    else $error("pipeline not empty after reset");

  // Gradients stay inside the Scharr range.
  a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
    grad_valid |-> grad.dx >= -32640 && grad.dx <= 32640 &&
                   grad.dy >= -32640 && grad.dy <= 32640)
    else $error("gradient out of range");

  // A stalled gradient holds until the tensor stage takes it.
  a_grad_hold: assert property (@(posedge clk) disable iff (!rst_n)
    grad_valid && !grad_ready |=> grad_valid && $stable(grad))
    else $error("gradient dropped or changed while stalled");

  // Results belong to interior centers and squares stay in range.
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.crow >= POS_W'(1) && res.ccol >= POS_W'(1) &&
                   res.xx <= SQ_W'(1016) && res.yy <= SQ_W'(1016))
    else $error("result field out of range");

endmodule

`default_nettype wire

### tb/scharr_structure_tensor_tb.sv
// ----------------------------------------------------------------------------
// scharr_structure_tensor_tb: self-checking bench for the structure tensor
// Streams grayscale images through the block and checks every tensor item
// against a cycle-free model of the line stores and the 3x3 Scharr window.
// A directed plan covers flat, striped and diagonal images, the width limits,
// mid-row width shrinks and frame restarts. Random frames with random width,
// size and backpressure follow.
// ----------------------------------------------------------------------------

module scharr_structure_tensor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 130;
  localparam int PRINT_LIMIT   = 40;

  typedef enum {PAT_FLAT, PAT_VSTRIPE, PAT_HSTRIPE, PAT_DIAG, PAT_NOISE, PAT_EXTREME}
    pattern_t;

  // One stretch of pixels sent under a single width setting.
  typedef struct {
    bit       set_width;     // write image_width first, once the block is idle
    int       width;
    bit       new_frame;     // first pixel carries frame_start
    int       pixels;
    pattern_t pat;
    int       level;         // gray level of a flat image
    int       restart_odds;  // 1 in N chance of a frame restart mid-stream, 0 = never
    bit       fixed;         // tensor values are known up front
    int       fx;
    int       fy;
    int       fxy;
  } segment_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;    // [7:0] pixel
  logic                  in_tuser;    // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready;
  // [9:0] grad_xx, [19:10] grad_yy, [30:20] grad_xy, [40:31] center_row,
  // [50:41] center_col, upper bits zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  scharr_structure_tensor i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Directed plan. Tensor values are typed in only for flat and striped images.
  segment_t directed_plan [9] = '{
    // Reset width of 1024, flat black: the first row gives no items.
    '{1'b0, 0,    1'b1, 16,          PAT_FLAT,    0,   0, 1'b1, 0,    0,    0},
    // Width 0 acts as 18; vertical stripes two pixels wide give the largest dx.
    '{1'b1, 0,    1'b1, 3 * 18,      PAT_VSTRIPE, 0,   0, 1'b1, 1016, 0,    0},
    // Width 17 acts as 18; horizontal stripes give the largest dy.
    '{1'b1, 17,   1'b1, 3 * 18,      PAT_HSTRIPE, 0,   0, 1'b1, 0,    1016, 0},
    // All register bits set acts as 1024; a short white run stays in row zero.
    '{1'b1, 2047, 1'b1, 16,          PAT_FLAT,    255, 0, 1'b1, 0,    0,    0},
    // Just above the maximum width, a short diagonal run in row zero.
    '{1'b1, 1025, 1'b1, 16,          PAT_DIAG,    0,   0, 1'b0, 0,    0,    0},
    // Width 24, stop partway into the third row.
    '{1'b1, 24,   1'b1, 2 * 24 + 21, PAT_NOISE,   0,   0, 1'b0, 0,    0,    0},
    // Shrink to 20 while the column is already past the new end of row.
    '{1'b1, 20,   1'b0, 31,          PAT_NOISE,   0,   0, 1'b0, 0,    0,    0},
    // Shrink to 18 while the column is still short of the new end of row.
    '{1'b1, 18,   1'b0, 24,          PAT_NOISE,   0,   0, 1'b0, 0,    0,    0},
    // Frame restart in the middle of a row, black and white pixels only.
    '{1'b0, 0,    1'b1, 3 * 18,      PAT_EXTREME, 0,   0, 1'b0, 0,    0,    0}
  };

  // Model state: line stores, the two previous window columns and position.
  logic [PIX_W-1:0] line_up  [MAX_WIDTH];
  logic [PIX_W-1:0] line_mid [MAX_WIDTH];
  logic [PIX_W-1:0] win_cols [6];
  int unsigned      cur_col;
  int unsigned      cur_row;
  logic [CFG_W-1:0] width_reg;

  res_t expected_tensors [$];
  int   mismatch_count;
  int   results_seen;
  int   pixels_sent;
  int   frames_started;
  int   quiet_cycles;
  int   ready_wait;
  bit   in_calm;
  bit   out_calm;

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned active_width();
    if (width_reg < MIN_WIDTH) return MIN_WIDTH;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  // 24*a + 80*b + 24*c as a plain integer.
  function automatic int col_sum(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                 input logic [PIX_W-1:0] c);
    return W_EDGE * (int'(a) + int'(c)) + W_MID * int'(b);
  endfunction

  // Advances the model by one pixel; returns 1 when the pixel completes an
  // interior window, with the tensor item in t.
  function automatic bit advance_window(input logic [PIX_W-1:0] pix, input bit fs,
                                        output res_t t);
    int               dx;
    int               dy;
    int unsigned      r;
    int unsigned      c;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    bit               hit;
    hit = 1'b0;
    t = '0;
    if (fs) begin
      cur_col = 0;
      cur_row = 0;
    end
    // Past the height limit nothing changes until the next frame start.
    if (cur_row >= MAX_HEIGHT) return 1'b0;
    r = cur_row;
    c = cur_col;
    top = line_up[c];
    mid = line_mid[c];
    if (r >= 2 && c >= 2) begin
      dx = col_sum(win_cols[0], win_cols[1], win_cols[2]) - col_sum(top, mid, pix);
      dy = col_sum(win_cols[0], win_cols[3], top) - col_sum(win_cols[2], win_cols[5], pix);
      t.xx   = SQ_W'((dx * dx) >>> FLOOR_SHIFT);
      t.yy   = SQ_W'((dy * dy) >>> FLOOR_SHIFT);
      t.xy   = XY_W'((dy * dx) >>> FLOOR_SHIFT);
      t.crow = POS_W'(r - 1);
      t.ccol = POS_W'(c - 1);
      hit = 1'b1;
    end
    line_up[c]  = mid;
    line_mid[c] = pix;
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = pix;
    if (c + 1 >= active_width()) begin
      cur_col = 0;
      cur_row = r + 1;
    end else begin
      cur_col = c + 1;
    end
    return hit;
  endfunction

  function automatic logic [PIX_W-1:0] pattern_pixel(input pattern_t pat, input int level,
                                                     input int unsigned r, input int unsigned c);
    case (pat)
      PAT_FLAT:    return PIX_W'(level);
      PAT_VSTRIPE: return ((c / 2) % 2) ? 8'd0 : 8'd255;
      PAT_HSTRIPE: return ((r / 2) % 2) ? 8'd0 : 8'd255;
      PAT_DIAG:    return (((r + c) / 2) % 2) ? 8'd0 : 8'd255;
      PAT_NOISE:   return PIX_W'($urandom_range(0, 255));
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default:     return 8'd0;
    endcase
  endfunction

  // Idle length before an item or a ready cycle: mostly none, a few long.
  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("ERROR: %s", what);
  endtask

  task automatic check_field(input string name, input int idx, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s of result %0d: got %0d, expected %0d",
                                name, idx, got, want));
  endtask

  // Waits until every expected item has arrived and the pipeline has emptied.
  task automatic wait_drained();
    while (expected_tensors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input int value);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = CFG_W'(value);
  endtask

  // Sends one segment of pixels and records the tensor items they cause.
  task automatic run_segment(input segment_t seg);
    res_t             t;
    logic [PIX_W-1:0] pix;
    bit               fs;
    int               gap;
    if (seg.set_width) write_width(seg.width);
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < seg.pixels; i++) begin
      fs = (seg.new_frame && i == 0) ||
           (seg.restart_odds > 0 && i > 0 && $urandom_range(1, seg.restart_odds) == 1);
      pix = pattern_pixel(seg.pat, seg.level, fs ? 0 : cur_row, fs ? 0 : cur_col);
      gap = pick_gap(in_calm);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= pix;
      in_tuser  <= fs;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      pixels_sent++;
      if (fs) frames_started++;
      if (advance_window(pix, fs, t)) begin
        if (seg.fixed) begin
          t.xx = SQ_W'(seg.fx);
          t.yy = SQ_W'(seg.fy);
          t.xy = XY_W'(seg.fxy);
        end
        expected_tensors = {expected_tensors, t};
      end
    end
  endtask

  // Result side: random backpressure.
  always @(posedge clk) begin
    if (ready_wait > 0) begin
      ready_wait = ready_wait - 1;
      out_tready <= 1'b0;
    end else begin
      ready_wait = pick_gap(out_calm);
      out_tready <= (ready_wait == 0);
    end
  end

  // Compare each accepted tensor item with the oldest expectation.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[RES_W-1:0]);
      if (expected_tensors.size() == 0) begin
        report_mismatch($sformatf("result %0d for row %0d col %0d arrived with nothing pending",
                                  results_seen, got.crow, got.ccol));
      end else begin
        want = expected_tensors.pop_front();
        check_field("grad_xx", results_seen, int'(got.xx), int'(want.xx));
        check_field("grad_yy", results_seen, int'(got.yy), int'(want.yy));
        check_field("grad_xy", results_seen, int'(got.xy), int'(want.xy));
        check_field("center_row", results_seen, int'(got.crow), int'(want.crow));
        check_field("center_col", results_seen, int'(got.ccol), int'(want.ccol));
        check_field("padding", results_seen, int'(out_tdata[OUT_TDATA_W-1:RES_W]), 0);
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any item moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without progress", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed plan, random frames, drain, verdict.
  initial begin
    int       random_pixels;
    int       w_eff;
    int       roll;
    segment_t seg;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    ready_wait  = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    results_seen = 0;
    pixels_sent = 0;
    frames_started = 0;
    random_pixels = 0;
    in_calm  = 1'b0;
    out_calm = 1'b0;
    cur_col = 0;
    cur_row = 0;
    width_reg = CFG_W'(MAX_WIDTH);
    foreach (win_cols[k]) win_cols[k] = '0;
    foreach (line_up[k]) begin
      line_up[k]  = '0;
      line_mid[k] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[k]) run_segment(directed_plan[k]);

    // Random frames: mostly small widths, some below the minimum.
    while (random_pixels < RANDOM_PIXELS) begin
      roll = $urandom_range(0, 9);
      seg.set_width = 1'b1;
      seg.width = (roll < 8) ? $urandom_range(MIN_WIDTH, 30) :
                  (roll == 8) ? $urandom_range(0, MIN_WIDTH - 1) : $urandom_range(31, 48);
      w_eff = (seg.width < MIN_WIDTH) ? MIN_WIDTH : seg.width;
      seg.new_frame = 1'b1;
      // A few frames are cut short before any window completes.
      if ($urandom_range(0, 7) == 0) seg.pixels = $urandom_range(1, 2 * w_eff);
      else seg.pixels = $urandom_range(2, 4) * w_eff + $urandom_range(0, w_eff - 1);
      if (seg.pixels > RANDOM_PIXELS - random_pixels) seg.pixels = RANDOM_PIXELS - random_pixels;
      roll = $urandom_range(0, 9);
      seg.pat = (roll < 6) ? PAT_NOISE : (roll < 8) ? PAT_EXTREME :
                (roll == 8) ? PAT_DIAG : PAT_VSTRIPE;
      seg.level = 0;
      seg.restart_odds = ($urandom_range(0, 3) == 0) ? 40 : 0;
      seg.fixed = 1'b0;
      seg.fx = 0;
      seg.fy = 0;
      seg.fxy = 0;
      run_segment(seg);
      random_pixels += seg.pixels;
      // Sometimes narrow the image partway through the frame.
      if (random_pixels < RANDOM_PIXELS && $urandom_range(0, 2) == 0) begin
        seg.width = $urandom_range(MIN_WIDTH, w_eff);
        seg.new_frame = 1'b0;
        seg.restart_odds = 0;
        seg.pixels = $urandom_range(w_eff, 2 * w_eff);
        if (seg.pixels > RANDOM_PIXELS - random_pixels)
          seg.pixels = RANDOM_PIXELS - random_pixels;
        run_segment(seg);
        random_pixels += seg.pixels;
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    $display("Sent %0d pixels in %0d frames; %0d tensor items compared.",
             pixels_sent, frames_started, results_seen);
    $display("Covered widths from 0 to 2047, mid-row shrinks, frame restarts and stalls.");
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
sv/sst_pkg.sv
sv/sst_ram.sv
sv/sst_grad.sv
sv/sst_tensor.sv
sv/scharr_structure_tensor.sv
tb/scharr_structure_tensor_tb.sv
